[rtl/anp_pkg.sv]
// Shared types and character constants for the ASCII number parser.
package anp_pkg;

    // Width of the result port, fixed by the interface.
    localparam int unsigned OUT_WIDTH = 64;

    // Width of the cast applied to a non-negative result in signed mode.
    localparam int unsigned CAST_WIDTH = 32;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Offset added to a letter digit after subtracting its base letter.
    localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

    // Parse phase, one-hot.
    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_ZERO  = 3'b010,
        PH_BODY  = 3'b100
    } phase_t;

    // Classification of one character.
    typedef struct packed {
        logic       is_nul;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } char_class_t;

endpackage

[rtl/anp_char_decode.sv]
// Character classifier: flags special characters and extracts the digit value.
module anp_char_decode (
    input  logic [7:0]           char_in,
    output anp_pkg::char_class_t cls
);
    import anp_pkg::*;

    logic [7:0] diff;

    // Pick the base character to subtract and classify the digit range.
    always_comb
    begin
        cls          = '0;
        diff         = '0;
        cls.is_nul   = (char_in == CH_NUL);
        cls.is_minus = (char_in == CH_MINUS);
        cls.is_zero  = (char_in == CH_ZERO);
        cls.is_x     = (char_in == CH_X);
        if (char_in inside {[CH_ZERO:CH_NINE]})
        begin
            diff       = char_in - CH_ZERO;
            cls.dec_ok = 1'b1;
            cls.hex_ok = 1'b1;
            cls.digit  = diff[3:0];
        end
        else if (char_in inside {[CH_LA:CH_LF]})
        begin
            diff       = char_in - CH_LA;
            cls.hex_ok = 1'b1;
            cls.digit  = diff[3:0] + HEX_LETTER_BASE;
        end
        else if (char_in inside {[CH_UA:CH_UF]})
        begin
            diff       = char_in - CH_UA;
            cls.hex_ok = 1'b1;
            cls.digit  = diff[3:0] + HEX_LETTER_BASE;
        end
    end

endmodule

[rtl/anp_parse_state.sv]
// Parse state registers, accumulator update and final value selection.
module anp_parse_state #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  anp_pkg::char_class_t   cls,
    input  logic                   signed_mode,
    output logic [VALUE_WIDTH-1:0] result
);
    import anp_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   hex_reg, hex_next;
    logic                   bad_reg, bad_next;

    logic                   digit_ok;
    logic [VALUE_WIDTH-1:0] acc_digit;
    logic [VALUE_WIDTH-1:0] digit_ext;

    // One digit in the current base: shift by four, or times ten as 8x + 2x.
    assign digit_ok  = hex_reg ? cls.hex_ok : cls.dec_ok;
    assign digit_ext = VALUE_WIDTH'(cls.digit);
    assign acc_digit = hex_reg ? ((acc_reg << 4) + digit_ext)
                               : ((acc_reg << 3) + (acc_reg << 1) + digit_ext);

    // Next state for the character in the input stage.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        hex_next   = hex_reg;
        bad_next   = bad_reg;
        if (step)
        begin
            if (cls.is_nul)
            begin
                phase_next = PH_START;
                acc_next   = '0;
                neg_next   = 1'b0;
                hex_next   = 1'b0;
                bad_next   = 1'b0;
            end
            else
            begin
                phase_next = PH_BODY;
                case (phase_reg)
                    PH_START:
                    begin
                        if (cls.is_minus && signed_mode)
                        begin
                            neg_next = 1'b1;
                        end
                        else if (cls.is_zero)
                        begin
                            acc_next   = '0;
                            phase_next = PH_ZERO;
                        end
                        else if (digit_ok)
                        begin
                            acc_next = acc_digit;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (cls.is_x)
                        begin
                            hex_next = 1'b1;
                            acc_next = '0;
                        end
                        else if (digit_ok)
                        begin
                            acc_next = acc_digit;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (digit_ok)
                        begin
                            acc_next = acc_digit;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Control state and accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            hex_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            hex_reg   <= hex_next;
            bad_reg   <= bad_next;
        end
    end

    // Final value: zero on error, negated, cast to 32 bits, or plain.
    always_comb
    begin
        if (bad_reg)
        begin
            result = '0;
        end
        else if (neg_reg)
        begin
            result = '0 - acc_reg;
        end
        else if (signed_mode)
        begin
            result = VALUE_WIDTH'($signed(acc_reg[CAST_WIDTH-1:0]));
        end
        else
        begin
            result = acc_reg;
        end
    end

endmodule

[rtl/ascii_number_parser_core.sv]
// Top level of the ASCII number parser: input stage, config and result register.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    char_in[7:0]
// out      output     out_valid / out_ready  value[63:0]
// cfg      input      cfg_wr_en              cfg_wr_data (signed_mode)
//
// One character is taken per cycle unless stalled; a result is registered from the NUL.
// The loop that sets this rate is the accumulator shift-add in the parse state.
// Reset clears the parse state and sets signed_mode to 1.
// A held result stalls the input stage only when that stage holds the next NUL.
module ascii_number_parser_core #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    char_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [anp_pkg::OUT_WIDTH-1:0] value,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data
);
    import anp_pkg::*;

    logic                   s1_valid_reg, s1_valid_next;
    logic [7:0]             s1_char_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   signed_mode_reg;

    char_class_t            cls;
    logic                   out_free;
    logic                   s1_step;
    logic                   in_take;
    logic [VALUE_WIDTH-1:0] result;

    anp_char_decode u_decode (
        .char_in (s1_char_reg),
        .cls     (cls)
    );

    anp_parse_state #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_step),
        .cls         (cls),
        .signed_mode (signed_mode_reg),
        .result      (result)
    );

    // Flow control: a NUL may leave the input stage only when the result slot is free.
    assign out_free      = !out_valid_reg || out_ready;
    assign s1_step       = s1_valid_reg && (!cls.is_nul || out_free);
    assign in_ready      = !s1_valid_reg || s1_step;
    assign in_take       = in_valid && in_ready;
    assign s1_valid_next = in_take ? 1'b1 : (s1_step ? 1'b0 : s1_valid_reg);

    // Result slot is loaded by a NUL and emptied when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_step && cls.is_nul)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            signed_mode_reg <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                signed_mode_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_in;
        end
        if (s1_step && cls.is_nul)
        begin
            value_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = OUT_WIDTH'(value_reg);

endmodule

[dv/anp_checker.sv]
// Checker for the ASCII number parser: tracks requests, predicts each parsed value and compares.
module anp_checker #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [7:0]                    char_in,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [anp_pkg::OUT_WIDTH-1:0] value,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import anp_pkg::*;

    localparam logic [OUT_WIDTH-1:0] VALUE_MASK = {OUT_WIDTH{1'b1}} >> (OUT_WIDTH - VALUE_WIDTH);
    localparam int RADIX_DEC = 10;
    localparam int RADIX_HEX = 16;

    // Mirror of the mode register and the per-string parse state.
    logic                 mode_signed = 1'b1;
    phase_t               parse_phase = PH_START;
    logic [OUT_WIDTH-1:0] acc         = '0;
    logic                 neg_seen    = 1'b0;
    logic                 hex_seen    = 1'b0;
    logic                 bad_seen    = 1'b0;
    int                   fail_count  = 0;

    // Parsed values still waiting to come out, oldest first.
    logic [OUT_WIDTH-1:0] parsed_values[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic void clear_string();
        parse_phase = PH_START;
        acc         = '0;
        neg_seen    = 1'b0;
        hex_seen    = 1'b0;
        bad_seen    = 1'b0;
    endfunction

    // Shifts one digit of the current radix into the accumulator; returns 0 for a non-digit.
    function automatic bit add_digit(input logic [7:0] c);
        logic [3:0] d;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = 4'(c - CH_ZERO);
        else if (hex_seen && c >= CH_LA && c <= CH_LF)
            d = 4'(c - CH_LA) + HEX_LETTER_BASE;
        else if (hex_seen && c >= CH_UA && c <= CH_UF)
            d = 4'(c - CH_UA) + HEX_LETTER_BASE;
        else
            return 1'b0;
        acc = (acc * (hex_seen ? RADIX_HEX : RADIX_DEC) + OUT_WIDTH'(d)) & VALUE_MASK;
        return 1'b1;
    endfunction

    // Value reported when the terminator arrives.
    function automatic logic [OUT_WIDTH-1:0] string_value();
        logic [OUT_WIDTH-1:0] v;
        if (bad_seen)
            return '0;
        if (neg_seen)
            return (~acc + 1'b1) & VALUE_MASK;
        if (mode_signed)
        begin
            v = {{(OUT_WIDTH - CAST_WIDTH){acc[CAST_WIDTH-1]}}, acc[CAST_WIDTH-1:0]};
            return v & VALUE_MASK;
        end
        return acc & VALUE_MASK;
    endfunction

    // Advances the parse by one accepted character.
    function automatic void take_char(input logic [7:0] c);
        if (c == CH_NUL)
        begin
            parsed_values.push_back(string_value());
            clear_string();
        end
        else if (parse_phase == PH_START)
        begin
            if (c == CH_MINUS && mode_signed)
            begin
                neg_seen    = 1'b1;
                parse_phase = PH_BODY;
            end
            else if (c == CH_ZERO)
            begin
                acc         = '0;
                parse_phase = PH_ZERO;
            end
            else
            begin
                if (!add_digit(c))
                    bad_seen = 1'b1;
                parse_phase = PH_BODY;
            end
        end
        else if (parse_phase == PH_ZERO)
        begin
            if (c == CH_X)
            begin
                hex_seen = 1'b1;
                acc      = '0;
            end
            else if (!add_digit(c))
            begin
                bad_seen = 1'b1;
            end
            parse_phase = PH_BODY;
        end
        else
        begin
            if (!add_digit(c))
                bad_seen = 1'b1;
        end
    endfunction

    // Results are checked before requests, since a result can never belong
    // to a terminator taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_signed = 1'b1;
            clear_string();
            parsed_values.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (parsed_values.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, value);
                    fail_count++;
                end
                else if (value !== parsed_values[0])
                begin
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, parsed_values[0], value);
                    fail_count++;
                    void'(parsed_values.pop_front());
                end
                else
                begin
                    void'(parsed_values.pop_front());
                end
            end
            if (in_valid && in_ready)
                take_char(char_in);
            // A mode write lands after any character taken at the same edge.
            if (cfg_wr_en)
                mode_signed = cfg_wr_data;
            outstanding <= parsed_values.size();
            mismatches  <= fail_count;
        end
    end

endmodule

[dv/testbench.sv]
// Top of the ASCII number parser testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import anp_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int CFG_SETTLE   = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASES       = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_STRINGS = 30;

    typedef logic [7:0] char_q_t[$];

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [7:0]           char_in     = '0;
    logic                 out_ready   = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [OUT_WIDTH-1:0] value;
    int                   mismatches;
    int                   outstanding;

    int hold_req    = 0;
    bit full_rate   = 1'b0;
    int chars_sent  = 0;
    int cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ascii_number_parser_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    anp_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int pause_len();
        int r;
        if (full_rate)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] dec_char();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return CH_ZERO + 8'(v);
        if (v < 16)
            return CH_LA + 8'(v - 10);
        return CH_UA + 8'(v - 16);
    endfunction

    // Digit count: mostly short, sometimes long enough to wrap the accumulator.
    function automatic int digit_count();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 12);
        return $urandom_range(13, 24);
    endfunction

    // One random string without its terminator: mostly well formed, the rest broken or noise.
    function automatic char_q_t random_string();
        char_q_t s;
        int      kind;
        int      n;
        int      pos;
        int      sel;
        kind = $urandom_range(0, 99);
        n    = digit_count();
        if (kind < 30)
        begin
            if ($urandom_range(0, 3) == 0)
                s.push_back(CH_ZERO);
            repeat (n) s.push_back(dec_char());
        end
        else if (kind < 55)
        begin
            s.push_back(CH_ZERO);
            s.push_back(CH_X);
            repeat (n) s.push_back(hex_char());
        end
        else if (kind < 75)
        begin
            s.push_back(CH_MINUS);
            repeat (n) s.push_back(dec_char());
        end
        else if (kind < 80)
        begin
            // Empty, bare prefix, bare sign or a lone zero.
            sel = $urandom_range(0, 3);
            if (sel == 1)
            begin
                s.push_back(CH_ZERO);
                s.push_back(CH_X);
            end
            else if (sel == 2)
                s.push_back(CH_MINUS);
            else if (sel == 3)
                s.push_back(CH_ZERO);
        end
        else if (kind < 92)
        begin
            // A well-formed string with one character replaced.
            if ($urandom_range(0, 1) == 0)
            begin
                s.push_back(CH_ZERO);
                s.push_back(CH_X);
                repeat (n) s.push_back(hex_char());
            end
            else
            begin
                repeat (n) s.push_back(dec_char());
            end
            pos = $urandom_range(0, s.size() - 1);
            sel = $urandom_range(0, 3);
            if (sel == 0)
                s[pos] = CH_X;
            else if (sel == 1)
                s[pos] = CH_MINUS;
            else
                s[pos] = 8'($urandom_range(1, 255));
        end
        else
        begin
            repeat (n) s.push_back(8'($urandom_range(1, 255)));
        end
        return s;
    endfunction

    // Offers one character and returns at the edge where it is taken.
    task automatic offer_char(input logic [7:0] c);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
    endtask

    task automatic send_string(input char_q_t s);
        foreach (s[i]) offer_char(s[i]);
        offer_char(CH_NUL);
    endtask

    // Stops offering until every parsed value has come out, then lets the block settle.
    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_mode(input logic signed_mode);
        wait_idle(CFG_SETTLE);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= signed_mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: random ready pattern, with a long hold-off on request.
    initial
    begin : result_sink
        int   span;
        logic level;
        forever
        begin
            if (hold_req > 0)
            begin
                level    = 1'b0;
                span     = hold_req;
                hold_req = 0;
            end
            else if (full_rate)
            begin
                level = 1'b1;
                span  = 1;
            end
            else
            begin
                level = ($urandom_range(0, 2) != 0);
                span  = level ? $urandom_range(1, 12) : pause_len() + 1;
            end
            out_ready <= level;
            repeat (span) @(posedge clk);
        end
    end

    // Cycle limit.
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        char_q_t text;
        int      target;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(1'b1);

        // Directed strings in signed mode: empty, negative, bare prefix,
        // mixed-case hex, a high-bit character, a bare sign, x after the prefix.
        text.delete();
        send_string(text);
        text = {CH_MINUS, CH_NINE};
        send_string(text);
        text = {CH_ZERO, CH_X};
        send_string(text);
        text = {CH_ZERO, CH_X, CH_LA, CH_UF};
        send_string(text);
        text = {8'hFF};
        send_string(text);
        text = {CH_MINUS};
        send_string(text);
        text = {CH_ZERO, CH_X, CH_X};
        send_string(text);

        // Mode switched to unsigned between the sign and the terminator.
        offer_char(CH_MINUS);
        offer_char(CH_ZERO + 8'd5);
        set_mode(1'b0);
        offer_char(CH_NUL);

        // A leading minus is a bad character in unsigned mode.
        text = {CH_MINUS, CH_ZERO + 8'd1};
        send_string(text);

        // Random phases alternating the mode; one runs with no idling at all.
        for (int p = 0; p < PHASES; p++)
        begin
            set_mode(1'(p % 2));
            full_rate = (p == 2);
            if (p == 1)
            begin
                // Hold results back while short strings keep coming, so the input stalls.
                hold_req = HOLD_CYCLES;
                text     = {CH_ZERO};
                repeat (HOLD_STRINGS) send_string(text);
            end
            target = chars_sent + RANDOM_ITEMS / PHASES;
            while (chars_sent < target)
                send_string(random_string());
        end

        full_rate = 1'b0;
        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
